FILE: src/urlq_pkg.sv
// urlq_pkg: shared types and constants for the UART receive line queue.
// Used by urlq_store and uart_rx_line_queue_unit; depends on nothing.
`timescale 1ns / 1ps

package urlq_pkg;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_POP  = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FIXCR = 3'b010,
		S_READ  = 3'b100
	} state_t;

	localparam byte_t NEWLINE         = 8'h0A;
	localparam byte_t CARRIAGE_RETURN = 8'h0D;
	localparam byte_t TERMINATOR      = 8'h00;

endpackage

FILE: src/uart_rx_line_queue_unit.sv
// uart_rx_line_queue_unit: UART receive queue with line and raw byte modes.
// Depends on urlq_pkg and urlq_store.
`timescale 1ns / 1ps

// A newline that follows a carriage return also passes through S_FIXCR,
// since the store has a single write port and the carriage return is zeroed
// in a second write. A pop or a slot read passes through S_READ: the store
// read is issued at the transfer and its registered data loads the output
// register in S_READ. In S_IDLE the next item is taken while a result
// waits in the output register if it is a received byte or no action, or if
// the waiting result is taken in the same cycle. Store contents are undefined
// until written; no clearing pass runs after reset. Writing raw_mode clears
// every index but keeps the store.
module uart_rx_line_queue_unit #(
	parameter int LINES    = 4,
	parameter int LINE_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] rx_byte,
	input  logic [1:0] slot_sel,
	input  logic [7:0] byte_offset,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	output logic [1:0] line_slot,
	output logic [7:0] data_byte
);

	localparam int STORE = LINES * LINE_LEN;
	localparam int AW    = $clog2(STORE);
	localparam int SW    = $clog2(LINES);
	localparam int PW    = $clog2(LINE_LEN);
	localparam logic [SW-1:0] LAST_SLOT = SW'(LINES - 1);
	localparam logic [PW-1:0] LAST_POS  = PW'(LINE_LEN - 1);
	localparam logic [AW-1:0] LAST_IDX  = AW'(STORE - 1);

	urlq_pkg::state_t state_q, state_d;

	logic          raw_mode_q;
	logic [SW-1:0] wr_slot_q, rd_slot_q;
	logic [PW-1:0] wr_pos_q;
	logic [AW-1:0] ring_wr_q, ring_rd_q;
	logic          last_cr_q;
	logic [AW-1:0] fix_addr_q;

	logic [SW-1:0] wr_slot_d, rd_slot_d;
	logic [PW-1:0] wr_pos_d;
	logic [AW-1:0] ring_wr_d, ring_rd_d;
	logic          last_cr_d;
	logic [AW-1:0] fix_addr_d;

	logic          found_s1, use_mem_s1;
	logic [1:0]    slot_s1;
	logic          found_d, use_mem_d;
	logic [1:0]    slot_d;

	logic          out_valid_q, out_found_q;
	logic [1:0]    out_slot_q;
	urlq_pkg::byte_t out_data_q;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	urlq_pkg::byte_t mem_wdata, mem_rdata;

	urlq_pkg::action_t act;
	logic          xfer;
	logic [SW-1:0] wr_slot_inc, rd_slot_inc;
	logic [AW-1:0] line_addr, slot_addr;
	logic          slot_ok;

	assign act = urlq_pkg::action_t'(action);

	always_comb begin
		in_ready = 1'b0;
		if (state_q == urlq_pkg::S_IDLE) begin
			in_ready = !out_valid_q || out_ready || act == urlq_pkg::ACT_BYTE ||
				act == urlq_pkg::ACT_NONE;
		end
	end

	assign xfer = in_valid && in_ready;

	assign wr_slot_inc = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
	assign rd_slot_inc = (rd_slot_q == LAST_SLOT) ? '0 : rd_slot_q + 1'b1;
	assign line_addr = AW'(32'(wr_slot_q) * 32'(LINE_LEN) + 32'(wr_pos_q));
	assign slot_ok = (32'(slot_sel) < 32'(LINES)) && (32'(byte_offset) < 32'(LINE_LEN));
	assign slot_addr = AW'(32'(slot_sel) * 32'(LINE_LEN) + 32'(byte_offset));

	always_comb begin
		state_d    = state_q;
		wr_slot_d  = wr_slot_q;
		rd_slot_d  = rd_slot_q;
		wr_pos_d   = wr_pos_q;
		ring_wr_d  = ring_wr_q;
		ring_rd_d  = ring_rd_q;
		last_cr_d  = last_cr_q;
		fix_addr_d = fix_addr_q;
		found_d    = found_s1;
		use_mem_d  = use_mem_s1;
		slot_d     = slot_s1;
		mem_we     = 1'b0;
		mem_waddr  = line_addr;
		mem_wdata  = rx_byte;
		mem_re     = 1'b0;
		mem_raddr  = ring_rd_q;

		case (state_q)
			urlq_pkg::S_IDLE: begin
				if (xfer) begin
					case (act)
						urlq_pkg::ACT_BYTE: begin
							if (raw_mode_q) begin
								mem_we    = 1'b1;
								mem_waddr = ring_wr_q;
								ring_wr_d = (ring_wr_q == LAST_IDX) ? '0 : ring_wr_q + 1'b1;
							end else if (rx_byte == urlq_pkg::NEWLINE) begin
								mem_we     = 1'b1;
								mem_wdata  = urlq_pkg::TERMINATOR;
								wr_pos_d   = '0;
								last_cr_d  = 1'b0;
								wr_slot_d  = wr_slot_inc;
								if (rd_slot_q == wr_slot_inc) begin
									rd_slot_d = rd_slot_inc;
								end
								// the byte before was written in this slot; zero it if CR
								fix_addr_d = line_addr - 1'b1;
								if (wr_pos_q != '0 && last_cr_q) begin
									state_d = urlq_pkg::S_FIXCR;
								end
							end else if (wr_pos_q < LAST_POS) begin
								mem_we    = 1'b1;
								wr_pos_d  = wr_pos_q + 1'b1;
								last_cr_d = (rx_byte == urlq_pkg::CARRIAGE_RETURN);
							end
						end
						urlq_pkg::ACT_POP: begin
							state_d   = urlq_pkg::S_READ;
							slot_d    = '0;
							use_mem_d = 1'b0;
							found_d   = 1'b0;
							if (raw_mode_q) begin
								if (ring_rd_q != ring_wr_q) begin
									found_d   = 1'b1;
									use_mem_d = 1'b1;
									mem_re    = 1'b1;
									ring_rd_d = (ring_rd_q == LAST_IDX) ? '0 : ring_rd_q + 1'b1;
								end
							end else if (wr_slot_q != rd_slot_q) begin
								found_d   = 1'b1;
								slot_d    = 2'(32'(rd_slot_q));
								rd_slot_d = rd_slot_inc;
							end
						end
						urlq_pkg::ACT_READ: begin
							state_d   = urlq_pkg::S_READ;
							slot_d    = '0;
							found_d   = slot_ok;
							use_mem_d = slot_ok;
							mem_re    = slot_ok;
							mem_raddr = slot_addr;
						end
						default: begin
						end
					endcase
				end
			end
			urlq_pkg::S_FIXCR: begin
				mem_we    = 1'b1;
				mem_waddr = fix_addr_q;
				mem_wdata = urlq_pkg::TERMINATOR;
				state_d   = urlq_pkg::S_IDLE;
			end
			urlq_pkg::S_READ: begin
				state_d = urlq_pkg::S_IDLE;
			end
			default: begin
				state_d = urlq_pkg::S_IDLE;
			end
		endcase
	end

	urlq_store #(
		.DEPTH(STORE),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= urlq_pkg::S_IDLE;
			raw_mode_q <= 1'b1;
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			wr_pos_q   <= '0;
			ring_wr_q  <= '0;
			ring_rd_q  <= '0;
			last_cr_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			// mode change: clear indices, keep store contents
			raw_mode_q <= cfg_wr_data;
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			wr_pos_q   <= '0;
			ring_wr_q  <= '0;
			ring_rd_q  <= '0;
			last_cr_q  <= 1'b0;
			state_q    <= state_d;
		end else begin
			state_q   <= state_d;
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			wr_pos_q  <= wr_pos_d;
			ring_wr_q <= ring_wr_d;
			ring_rd_q <= ring_rd_d;
			last_cr_q <= last_cr_d;
		end
	end

	always_ff @(posedge clk) begin
		fix_addr_q <= fix_addr_d;
		found_s1   <= found_d;
		use_mem_s1 <= use_mem_d;
		slot_s1    <= slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == urlq_pkg::S_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == urlq_pkg::S_READ) begin
			out_found_q <= found_s1;
			out_slot_q  <= slot_s1;
			out_data_q  <= use_mem_s1 ? mem_rdata : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign line_slot = out_slot_q;
	assign data_byte = out_data_q;

`ifndef SYNTH
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == urlq_pkg::S_IDLE)
		else $error("input taken outside idle");

	a_read_finds_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urlq_pkg::S_READ |-> !out_valid_q)
		else $error("result pending when store read returns");

	a_read_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urlq_pkg::S_READ |=> out_valid_q)
		else $error("store read did not load output");

	a_pos_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pos_q <= LAST_POS)
		else $error("line write position past end of slot");

	a_fixcr_after_nl: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urlq_pkg::S_FIXCR |-> $past(mem_we) && $past(xfer))
		else $error("carriage return fix without newline write");
`endif

endmodule

FILE: src/urlq_store.sv
// urlq_store: byte store of the receive queue, one write and one read port.
// Read data is registered. Depends on urlq_pkg.
`timescale 1ns / 1ps

module urlq_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  urlq_pkg::byte_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output urlq_pkg::byte_t rdata
);

	urlq_pkg::byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
